### hw/rtl/csdm_pkg.sv
`timescale 1ns / 1ps
package csdm_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int ANGLE_STAGES = 16;

  // Centered coordinates, sector magnitudes and the divider.
  localparam int CTR_W  = SAMPLE_BITS + 2;
  localparam int MAG_W  = SAMPLE_BITS;
  localparam int QUO_W  = 30;
  localparam int PROD_W = MAG_W + QUO_W;

  // CORDIC datapath in Q32 with a few guard bits.
  localparam int VEC_W = 36;
  localparam int ANG_W = 32;

  localparam logic [QUO_W-1:0] PI4_Q30  = 30'd843314857;
  localparam logic [QUO_W-1:0] GAIN_Q30 = 30'd652032874;

  typedef enum logic [1:0] {
    SECT_RIGHT = 2'd0,
    SECT_TOP   = 2'd1,
    SECT_LEFT  = 2'd2,
    SECT_BOT   = 2'd3
  } csdm_sect_t;

  // Sideband that rides along the divider stages.
  typedef struct packed {
    csdm_sect_t               sect;
    logic                     neg;
    logic signed [VEC_W-1:0]  x0;
  } csdm_div_side_t;

  // Micro-rotation angle of CORDIC stage i, Q30 radians.
  function automatic logic signed [ANG_W-1:0] csdm_stage_angle(input int i);
    logic signed [ANG_W-1:0] a;
    a = '0;
    unique case (i)
      0:       a = 32'sd843314857;
      1:       a = 32'sd497837829;
      2:       a = 32'sd263043837;
      3:       a = 32'sd133525159;
      4:       a = 32'sd67021687;
      5:       a = 32'sd33543516;
      6:       a = 32'sd16775851;
      7:       a = 32'sd8388437;
      8:       a = 32'sd4194283;
      9:       a = 32'sd2097149;
      default: begin
        if (i <= 30) a = ANG_W'(64'sd1 <<< (30 - i));
        else a = '0;
      end
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/csdm_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per pipeline stage.
module csdm_div import csdm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [PROD_W-1:0]    in_prod,
  input  logic [MAG_W-1:0]     in_den,
  input  csdm_div_side_t       in_side,
  output logic                 out_valid,
  output logic [QUO_W-1:0]     out_quo,
  output csdm_div_side_t       out_side
);

  logic                 st_v    [0:QUO_W];
  logic [MAG_W-1:0]     st_rem  [0:QUO_W];
  logic [QUO_W-1:0]     st_low  [0:QUO_W];
  logic [QUO_W-1:0]     st_quo  [0:QUO_W];
  logic [MAG_W-1:0]     st_den  [0:QUO_W];
  csdm_div_side_t       st_side [0:QUO_W];

  // The high part of the dividend is already below the divisor.
  assign st_v[0]    = in_valid;
  assign st_rem[0]  = in_prod[PROD_W-1:QUO_W];
  assign st_low[0]  = in_prod[QUO_W-1:0];
  assign st_quo[0]  = '0;
  assign st_den[0]  = in_den;
  assign st_side[0] = in_side;

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic                 v_r;
    logic [MAG_W-1:0]     rem_r;
    logic [QUO_W-1:0]     low_r;
    logic [QUO_W-1:0]     quo_r;
    logic [MAG_W-1:0]     den_r;
    csdm_div_side_t       side_r;
    logic [MAG_W:0]       trial;
    logic [MAG_W:0]       diff;
    logic                 ge;

    always_comb begin
      trial = {st_rem[g], st_low[g][QUO_W-1]};
      diff  = trial - {1'b0, st_den[g]};
      ge    = trial >= {1'b0, st_den[g]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= st_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        low_r  <= {st_low[g][QUO_W-2:0], 1'b0};
        quo_r  <= {st_quo[g][QUO_W-2:0], ge};
        den_r  <= st_den[g];
        side_r <= st_side[g];
      end
    end

    assign st_v[g+1]    = v_r;
    assign st_rem[g+1]  = rem_r;
    assign st_low[g+1]  = low_r;
    assign st_quo[g+1]  = quo_r;
    assign st_den[g+1]  = den_r;
    assign st_side[g+1] = side_r;
  end

  assign out_valid = st_v[QUO_W];
  assign out_quo   = st_quo[QUO_W];
  assign out_side  = st_side[QUO_W];

endmodule

### hw/rtl/csdm_cordic.sv
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per pipeline stage.
module csdm_cordic import csdm_pkg::*; #(
  parameter int STAGES = ANGLE_STAGES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [VEC_W-1:0] in_x,
  input  logic signed [ANG_W-1:0] in_ang,
  input  csdm_sect_t              in_sect,
  output logic                    out_valid,
  output logic signed [VEC_W-1:0] out_x,
  output logic signed [VEC_W-1:0] out_y,
  output csdm_sect_t              out_sect
);

  logic                    st_v    [0:STAGES];
  logic signed [VEC_W-1:0] st_x    [0:STAGES];
  logic signed [VEC_W-1:0] st_y    [0:STAGES];
  logic signed [ANG_W-1:0] st_ang  [0:STAGES];
  csdm_sect_t              st_sect [0:STAGES];

  assign st_v[0]    = in_valid;
  assign st_x[0]    = in_x;
  assign st_y[0]    = '0;
  assign st_ang[0]  = in_ang;
  assign st_sect[0] = in_sect;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam logic signed [ANG_W-1:0] StepAng = csdm_stage_angle(g);
    logic                    v_r;
    logic signed [VEC_W-1:0] x_r;
    logic signed [VEC_W-1:0] y_r;
    logic signed [ANG_W-1:0] ang_r;
    csdm_sect_t              sect_r;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    always_comb begin
      dx = st_y[g] >>> g;
      dy = st_x[g] >>> g;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= st_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!st_ang[g][ANG_W-1]) begin
          x_r   <= st_x[g] - dx;
          y_r   <= st_y[g] + dy;
          ang_r <= st_ang[g] - StepAng;
        end else begin
          x_r   <= st_x[g] + dx;
          y_r   <= st_y[g] - dy;
          ang_r <= st_ang[g] + StepAng;
        end
        sect_r <= st_sect[g];
      end
    end

    assign st_v[g+1]    = v_r;
    assign st_x[g+1]    = x_r;
    assign st_y[g+1]    = y_r;
    assign st_ang[g+1]  = ang_r;
    assign st_sect[g+1] = sect_r;
  end

  assign out_valid = st_v[STAGES];
  assign out_x     = st_x[STAGES];
  assign out_y     = st_y[STAGES];
  assign out_sect  = st_sect[STAGES];

endmodule

### hw/rtl/concentric_square_to_disk_map.sv
`timescale 1ns / 1ps
// An input beat passes the stage 1 and stage 2 registers, the divider, the CORDIC
// and the output buffer. Throughput: one beat per cycle while the buffer has room,
// set by the fully pipelined divider and CORDIC; a full buffer stalls the pipeline.
// A two-entry output buffer lets new input beats enter while one result waits.
// Reset is synchronous and active low; it clears all valid bits and the buffer.
module concentric_square_to_disk_map import csdm_pkg::*; #(
  parameter int ANGLE_STAGES_P = ANGLE_STAGES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_BITS-1:0]   in_square_x,
  input  logic [SAMPLE_BITS-1:0]   in_square_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       out_disk_x,
  output logic signed [15:0]       out_disk_y
);

  localparam int HALF = 1 << (SAMPLE_BITS - 1);
  localparam int XSH  = QUO_W - (33 - SAMPLE_BITS);

  // The whole pipeline moves as one while the output buffer has room.
  logic       en;
  logic [1:0] cnt_r, cnt_nxt;

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: center the sample and pick the sector. In every sector the radius
  // equals the divisor but at the origin; the numerator magnitude never exceeds it.
  // ---------------------------------------------------------------------------
  logic signed [CTR_W-1:0] sx, sy, num;
  logic [MAG_W-1:0]        r_c, mag_c;
  logic                    neg_c;
  csdm_sect_t              sect_c;

  always_comb begin
    sx = $signed({2'b00, in_square_x}) - CTR_W'(HALF);
    sy = $signed({2'b00, in_square_y}) - CTR_W'(HALF);
    if (sx > -sy) begin
      if (sx > sy) begin
        r_c = MAG_W'(sx);   num = sy;  sect_c = SECT_RIGHT;
      end else begin
        r_c = MAG_W'(sy);   num = -sx; sect_c = SECT_TOP;
      end
    end else begin
      if (sx < sy) begin
        r_c = MAG_W'(-sx);  num = -sy; sect_c = SECT_LEFT;
      end else begin
        r_c = MAG_W'(-sy);  num = sx;  sect_c = SECT_BOT;
      end
    end
    neg_c = num[CTR_W-1];
    mag_c = neg_c ? MAG_W'(-num) : MAG_W'(num);
  end

  logic             s1_v_r;
  logic [MAG_W-1:0] s1_r_r, s1_mag_r;
  logic             s1_neg_r;
  csdm_sect_t       s1_sect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r_r    <= r_c;
      s1_mag_r  <= mag_c;
      s1_neg_r  <= neg_c;
      s1_sect_r <= sect_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: dividend for the angle ratio and the gain-corrected start radius.
  // At the origin the numerator is zero, so a divisor of one gives angle zero.
  // ---------------------------------------------------------------------------
  logic                s2_v_r;
  logic [PROD_W-1:0]   s2_prod_r;
  logic [MAG_W-1:0]    s2_den_r;
  csdm_div_side_t      s2_side_r;
  logic [PROD_W-1:0]   gain_prod;

  assign gain_prod = PROD_W'(s1_r_r) * PROD_W'(GAIN_Q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod_r      <= PROD_W'(s1_mag_r) * PROD_W'(PI4_Q30);
      s2_den_r       <= (s1_r_r == '0) ? MAG_W'(1) : s1_r_r;
      s2_side_r.sect <= s1_sect_r;
      s2_side_r.neg  <= s1_neg_r;
      s2_side_r.x0   <= $signed(VEC_W'(gain_prod >> XSH));
    end
  end

  // ---------------------------------------------------------------------------
  // Angle ratio: quotient of the dividend by the radius, one bit per stage.
  // ---------------------------------------------------------------------------
  logic              dv_v;
  logic [QUO_W-1:0]  dv_quo;
  csdm_div_side_t    dv_side;

  csdm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_v_r),
    .in_prod   (s2_prod_r),
    .in_den    (s2_den_r),
    .in_side   (s2_side_r),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // The quotient sign follows the numerator, truncating toward zero.
  logic signed [ANG_W-1:0] ang;
  assign ang = dv_side.neg ? -$signed(ANG_W'(dv_quo)) : $signed(ANG_W'(dv_quo));

  // ---------------------------------------------------------------------------
  // Rotate the start vector by the remainder angle within the sector.
  // ---------------------------------------------------------------------------
  logic                    cr_v;
  logic signed [VEC_W-1:0] cr_x, cr_y;
  csdm_sect_t              cr_sect;

  csdm_cordic #(.STAGES(ANGLE_STAGES_P)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_v),
    .in_x      (dv_side.x0),
    .in_ang    (ang),
    .in_sect   (dv_side.sect),
    .out_valid (cr_v),
    .out_x     (cr_x),
    .out_y     (cr_y),
    .out_sect  (cr_sect)
  );

  // ---------------------------------------------------------------------------
  // Output stage: exact quarter-turn for the sector base angle, then round to
  // Q1.15 and saturate so that +1.0 lands on the largest code.
  // ---------------------------------------------------------------------------
  logic signed [VEC_W-1:0] qx, qy;

  always_comb begin
    unique case (cr_sect)
      SECT_TOP:  begin qx = -cr_y; qy = cr_x;  end
      SECT_LEFT: begin qx = -cr_x; qy = -cr_y; end
      SECT_BOT:  begin qx = cr_y;  qy = -cr_x; end
      default:   begin qx = cr_x;  qy = cr_y;  end
    endcase
  end

  function automatic logic signed [15:0] to_q15(input logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] s;
    s = (v + VEC_W'(1 << 16)) >>> 17;
    if (s > VEC_W'(32767)) return 16'sh7fff;
    if (s < -VEC_W'(32768)) return 16'sh8000;
    return s[15:0];
  endfunction

  logic        push, pop;
  logic [15:0] res_x, res_y;

  assign res_x = to_q15(qx);
  assign res_y = to_q15(qy);
  assign push  = cr_v && en;
  assign pop   = out_valid && out_ready;

  // ---------------------------------------------------------------------------
  // Two-entry output buffer that decouples the pipeline from the consumer.
  // ---------------------------------------------------------------------------
  logic [15:0] buf_x_r [0:1];
  logic [15:0] buf_y_r [0:1];
  logic        wr_ptr_r, rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_x_r[wr_ptr_r] <= res_x;
      buf_y_r[wr_ptr_r] <= res_y;
    end
  end

  assign out_valid  = (cnt_r != 2'd0);
  assign out_disk_x = $signed(buf_x_r[rd_ptr_r]);
  assign out_disk_y = $signed(buf_y_r[rd_ptr_r]);

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cr_v && en && cnt_r == 2'd2)) else $error("result pushed into full buffer");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd1) |-> (wr_ptr_r == rd_ptr_r)) else $error("buffer pointers out of step");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cr_v)) else $error("pipeline moved while stalled");
`endif

endmodule

### tb/sv/tb_concentric_square_to_disk_map.sv
`timescale 1ns / 1ps
module tb_concentric_square_to_disk_map;
  import csdm_pkg::*;

  // Disk-point predictor: computes the expected pair for one sample and keeps
  // the pending pairs in arrival order so each output beat can be checked.
  class disk_point_board;
    logic [15:0] want_x[$];
    logic [15:0] want_y[$];
    int errors;

    function automatic longint shr_floor(longint v, int s);
      return v >>> s;
    endfunction

    function automatic logic [15:0] round_q15(longint v);
      longint o;
      o = shr_floor(v + 64'sd65536, 17);
      if (o > 32767) o = 32767;
      if (o < -32768) o = -32768;
      return o[15:0];
    endfunction

    function automatic longint rot_angle(int i);
      longint tbl[10];
      tbl = '{843314857, 497837829, 263043837, 133525159, 67021687,
              33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return tbl[i];
      if (i <= 30) return 64'sd1 << (30 - i);
      return 0;
    endfunction

    function void note_sample(logic [15:0] sq_x, logic [15:0] sq_y);
      longint cx, cy, rad, num, den, ang, vx, vy, dx, dy, t, mag;
      csdm_sect_t sect;
      cx = longint'(sq_x) - 32768;
      cy = longint'(sq_y) - 32768;
      if (cx > -cy) begin
        if (cx > cy) begin
          rad = cx; num = cy; den = cx; sect = SECT_RIGHT;
        end else begin
          rad = cy; num = -cx; den = cy; sect = SECT_TOP;
        end
      end else begin
        if (cx < cy) begin
          rad = -cx; num = -cy; den = -cx; sect = SECT_LEFT;
        end else begin
          rad = -cy; num = cx; den = -cy; sect = SECT_BOT;
        end
      end
      if (den <= 0) begin
        ang = 0;
      end else begin
        mag = (num < 0) ? -num : num;
        ang = (mag * 843314857) / den;
        if (num < 0) ang = -ang;
      end
      // Radius moved to Q32 and pre-scaled by the CORDIC gain.
      vx = ((rad << 17) * 652032874) >>> 30;
      vy = 0;
      for (int i = 0; i < ANGLE_STAGES; i++) begin
        dx = shr_floor(vy, i);
        dy = shr_floor(vx, i);
        if (ang >= 0) begin
          vx -= dx; vy += dy; ang -= rot_angle(i);
        end else begin
          vx += dx; vy -= dy; ang += rot_angle(i);
        end
      end
      // The sector base angle is an exact quarter-turn swap.
      case (sect)
        SECT_TOP: begin
          t = vx; vx = -vy; vy = t;
        end
        SECT_LEFT: begin
          vx = -vx; vy = -vy;
        end
        SECT_BOT: begin
          t = vx; vx = vy; vy = -t;
        end
        default: ;
      endcase
      want_x = {want_x, round_q15(vx)};
      want_y = {want_y, round_q15(vy)};
    endfunction

    function void check_point(logic [15:0] got_x, logic [15:0] got_y);
      logic [15:0] ex, ey;
      if (want_x.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d", $time,
                 $signed(got_x), $signed(got_y));
        errors++;
        return;
      end
      ex = want_x.pop_front();
      ey = want_y.pop_front();
      if (got_x !== ex) begin
        $display("%0t: disk_x expected %0d actual %0d", $time, $signed(ex), $signed(got_x));
        errors++;
      end
      if (got_y !== ey) begin
        $display("%0t: disk_y expected %0d actual %0d", $time, $signed(ey), $signed(got_y));
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_square_x = '0;
  logic [15:0] in_square_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_disk_x;
  logic signed [15:0] out_disk_y;

  disk_point_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  concentric_square_to_disk_map u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_square_x(in_square_x), .in_square_y(in_square_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_disk_x(out_disk_x), .out_disk_y(out_disk_y)
  );

  // Output side: check each accepted beat, and draw out_ready for the next
  // edge at random according to the stall rate of the current phase.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) board.check_point(out_disk_x, out_disk_y);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycle_count > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sends one sample beat; random idle cycles precede it. Valid stays high
  // across back-to-back beats, so it is only assigned once per edge.
  task automatic send_sample(logic [15:0] sq_x, logic [15:0] sq_y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_square_x <= sq_x;
    in_square_y <= sq_y;
    do @(posedge clk); while (!in_ready);
    board.note_sample(sq_x, sq_y);
  endtask

  task automatic send_random(int count);
    logic [15:0] a, b;
    for (int n = 0; n < count; n++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      // Bias some samples onto the diagonals, where the sector boundaries
      // live, and next to the axes through the center.
      case ($urandom_range(7))
        0: b = a;
        1: b = 16'(65536 - a);
        2: a = 16'(16'h8000 + $urandom_range(3) - 1);
        3: b = 16'(16'h8000 + $urandom_range(3) - 1);
        default: ;
      endcase
      send_sample(a, b);
    end
  endtask

  initial begin
    logic [15:0] corner[6];
    corner = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: the origin, the corners, the edges and the sector boundaries.
    foreach (corner[i]) send_sample(corner[i], corner[i]);
    for (int i = 0; i < 6; i += 2) begin
      send_sample(corner[i], corner[5 - i]);
      send_sample(corner[i], 16'h8000);
      send_sample(16'h8000, corner[i + 1]);
    end
    send_sample(16'hAAAA, 16'h5555);
    send_sample(16'h5555, 16'hAAAA);
    // Random phases with different idle and stall rates.
    send_random(190);
    send_idle_pct = 62;
    send_random(185);
    send_idle_pct = 0;
    recv_stall_pct = 62;
    send_random(185);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    send_random(185);
    in_valid <= 1'b0;
    while (board.want_x.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
